FILE: src/tracked_device_table_with_ageout_defines.svh
// Assertion macros shared by the table's RTL.
`ifndef TRACKED_DEVICE_TABLE_WITH_AGEOUT_DEFINES_SVH
`define TRACKED_DEVICE_TABLE_WITH_AGEOUT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TDT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TDT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/tdt_pkg.sv
`default_nettype none

package tdt_pkg;

  // Field widths.
  localparam int MAC_W  = 48;
  localparam int TIME_W = 32;
  localparam int RSSI_W = 8;
  localparam int SRC_W  = 2;
  localparam int SLOT_W = 5;
  localparam int CNT_W  = 6;

  // Saturation value of the expired entry count.
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Reset value of the expiry time register.
  localparam logic [TIME_W-1:0] EXPIRE_RESET_MS = 32'd30000;

  // Operation codes.
  localparam logic OP_SIGHTING = 1'b0;
  localparam logic OP_SWEEP    = 1'b1;

  // Configuration register indexes.
  localparam logic REG_REDISCOVER = 1'b0;
  localparam logic REG_EXPIRE     = 1'b1;

  // One table row as held in memory.
  typedef struct packed {
    logic [MAC_W-1:0]  mac;
    logic [TIME_W-1:0] seen;
    logic [TIME_W-1:0] rpt;
    logic [RSSI_W-1:0] rssi;
  } tdt_row_t;

  // One input item.
  typedef struct packed {
    logic               op;
    logic [MAC_W-1:0]   mac;
    logic signed [RSSI_W-1:0] rssi;
    logic [SRC_W-1:0]   source;
    logic [TIME_W-1:0]  now;
  } tdt_item_t;

  // One result item.
  typedef struct packed {
    logic               report;
    logic [SLOT_W-1:0]  slot;
    logic               new_entry;
    logic               took_over;
    logic [MAC_W-1:0]   mac;
    logic signed [RSSI_W-1:0] rssi;
    logic [SRC_W-1:0]   source;
    logic [CNT_W-1:0]   expired;
  } tdt_result_t;

  // Status from the controller to the top level.
  typedef struct packed {
    logic busy;
    logic done;
  } tdt_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } tdt_state_t;

endpackage

`default_nettype wire

FILE: src/tracked_device_table_with_ageout.sv
// Table of recently seen radio transmitters, keyed by 48-bit address, with
// aging. A sighting beat finds the valid entry holding its address, or takes
// the lowest free entry, or takes over entry 0 when the table is full; it
// stores the time and strength and reports unless the entry's last report is
// younger than rediscover_ms (a stored report time of zero counts as never
// reported). A sweep beat drops every valid entry older than expire_ms and
// returns the count. Each beat gives one result beat. The table rows sit in
// one memory with a registered read, scanned one entry per cycle; the valid
// bits are flip-flops cleared by reset, so no clearing pass is needed. A
// sweep or a sighting without a match scans every entry; a sighting that
// matches entry k ends its scan there. The next input beat is taken while
// the last result waits on out_stall. Configuration is written through
// cfg_write, cfg_index and cfg_data: index 0 is rediscover_ms, index 1 is
// expire_ms.
`default_nettype none

`include "tracked_device_table_with_ageout_defines.svh"

module tracked_device_table_with_ageout
  import tdt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_write,
  input  wire logic                     cfg_index,
  input  wire logic [TIME_W-1:0]        cfg_data,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     op,
  input  wire logic [MAC_W-1:0]         mac,
  input  wire logic signed [RSSI_W-1:0] rssi,
  input  wire logic [SRC_W-1:0]         source,
  input  wire logic [TIME_W-1:0]        now_ms,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic                          report,
  output logic [SLOT_W-1:0]             slot,
  output logic                          new_entry,
  output logic                          took_over,
  output logic [MAC_W-1:0]              report_mac,
  output logic signed [RSSI_W-1:0]      report_rssi,
  output logic [SRC_W-1:0]              report_source,
  output logic [CNT_W-1:0]              expired_count
);

  logic [TIME_W-1:0] rediscover_ms;
  logic [TIME_W-1:0] expire_ms;
  tdt_item_t         item_in;
  tdt_result_t       res;
  tdt_result_t       res_q;
  tdt_ctl_t          ctl;
  logic              res_ready;
  logic              in_beat;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rediscover_ms <= '0;
      expire_ms     <= EXPIRE_RESET_MS;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_REDISCOVER: rediscover_ms <= cfg_data;
        REG_EXPIRE:     expire_ms     <= cfg_data;
        default:        expire_ms     <= expire_ms;
      endcase
    end
  end

  // Input beat.
  assign item_in.op     = op;
  assign item_in.mac    = mac;
  assign item_in.rssi   = rssi;
  assign item_in.source = source;
  assign item_in.now    = now_ms;
  assign in_stall       = ctl.busy;
  assign in_beat        = in_valid && !in_stall;

  tdt_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (in_valid),
    .item_in      (item_in),
    .rediscover_ms(rediscover_ms),
    .expire_ms    (expire_ms),
    .res_ready    (res_ready),
    .ctl          (ctl),
    .res          (res)
  );

  // Output register; it frees when empty or when its beat is taken.
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.done) begin
      res_q <= res;
    end
  end

  assign report        = res_q.report;
  assign slot          = res_q.slot;
  assign new_entry     = res_q.new_entry;
  assign took_over     = res_q.took_over;
  assign report_mac    = res_q.mac;
  assign report_rssi   = res_q.rssi;
  assign report_source = res_q.source;
  assign expired_count = res_q.expired;

  // One item is in work at a time.
  `TDT_ASSERT_NEXT(a_one_item, clk, rst, in_beat, in_stall, "item accepted while busy")

  // A takeover always lands on entry 0 as a new reporting entry.
  `TDT_ASSERT_SAME(a_takeover, clk, rst, ctl.done && res.took_over,
                   res.new_entry && (res.slot == '0) && res.report,
                   "takeover result inconsistent")

  // A freshly allocated entry has no earlier report and so always reports.
  `TDT_ASSERT_SAME(a_fresh_reports, clk, rst, ctl.done && res.new_entry,
                   res.report && (res.expired == '0), "new entry did not report")

endmodule

`default_nettype wire

FILE: src/tdt_mem.sv
`default_nettype none

module tdt_mem
  import tdt_pkg::*;
#(
  parameter int DEPTH  = 32,
  parameter int ADDR_W = 5
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire tdt_row_t          wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output tdt_row_t               rd_data
);

  tdt_row_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: src/tdt_ctrl.sv
`default_nettype none

module tdt_ctrl
  import tdt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire tdt_item_t         item_in,
  input  wire logic [TIME_W-1:0] rediscover_ms,
  input  wire logic [TIME_W-1:0] expire_ms,
  input  wire logic              res_ready,
  output tdt_ctl_t               ctl,
  output tdt_result_t            res
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W:0]   ENTRIES_CNT = (IDX_W+1)'(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(TABLE_ENTRIES - 1);

  tdt_state_t state, state_next;

  tdt_item_t           item;
  logic [IDX_W:0]      cnt;
  logic                chk_pend;
  logic [IDX_W-1:0]    chk_idx;
  logic                hit;
  logic [IDX_W-1:0]    hit_idx;
  logic [TIME_W-1:0]   hit_rpt;
  logic                free_found;
  logic [IDX_W-1:0]    free_idx;
  logic [CNT_W-1:0]    drop_cnt;
  logic [TABLE_ENTRIES-1:0] valid;

  logic                rd_en;
  logic [IDX_W-1:0]    rd_addr;
  tdt_row_t            rd_data;
  logic                wr_en;
  logic [IDX_W-1:0]    sel_idx;
  tdt_row_t            wr_data;

  logic                chk_fire;
  logic                chk_last;
  logic                entry_v;
  logic                mac_match;
  logic [TIME_W-1:0]   age;
  logic                aged;
  logic [TIME_W-1:0]   rpt_age;
  logic                rep;
  logic                finish;

  tdt_mem #(
    .DEPTH (TABLE_ENTRIES),
    .ADDR_W(IDX_W)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(sel_idx),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Check of the entry whose row arrived from memory this cycle.
  assign rd_addr   = cnt[IDX_W-1:0];
  assign chk_fire  = (state == ST_SCAN) && chk_pend;
  assign chk_last  = (chk_idx == LAST_IDX);
  assign entry_v   = valid[chk_idx];
  assign mac_match = chk_fire && (item.op == OP_SIGHTING) && entry_v &&
                     (rd_data.mac == item.mac);
  assign age       = item.now - rd_data.seen;
  assign aged      = age > expire_ms;

  // Entry chosen by a sighting: the match, else the lowest free entry, else entry 0.
  assign sel_idx = hit ? hit_idx : (free_found ? free_idx : '0);
  assign rpt_age = item.now - hit_rpt;
  assign rep     = hit ? !((hit_rpt != '0) && (rpt_age < rediscover_ms)) : 1'b1;

  assign wr_data.mac  = item.mac;
  assign wr_data.seen = item.now;
  assign wr_data.rpt  = rep ? item.now : hit_rpt;
  assign wr_data.rssi = item.rssi;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (chk_fire && (mac_match || chk_last)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    rd_en    = 1'b0;
    finish   = 1'b0;
    ctl.busy = 1'b1;
    unique case (state)
      ST_IDLE: begin
        ctl.busy = 1'b0;
      end
      ST_SCAN: begin
        rd_en = (cnt < ENTRIES_CNT);
      end
      ST_FINISH: begin
        finish = res_ready;
      end
      default: ctl.busy = 1'b1;
    endcase
    ctl.done = finish;
    wr_en    = finish && (item.op == OP_SIGHTING);
  end

  // Result of the finished item.
  always_comb begin
    res = '0;
    if (item.op == OP_SWEEP) begin
      res.expired = drop_cnt;
    end else begin
      res.report    = rep;
      res.slot      = SLOT_W'(sel_idx);
      res.new_entry = !hit;
      res.took_over = !hit && !free_found;
      res.mac       = item.mac;
      res.rssi      = item.rssi;
      res.source    = item.source;
    end
  end

  // Control state, scan bookkeeping and valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      chk_pend   <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      drop_cnt   <= '0;
      valid      <= '0;
    end else begin
      state <= state_next;
      if (start && (state == ST_IDLE)) begin
        cnt        <= '0;
        chk_pend   <= 1'b0;
        hit        <= 1'b0;
        free_found <= 1'b0;
        drop_cnt   <= '0;
      end
      if (state == ST_SCAN) begin
        chk_pend <= rd_en;
        if (rd_en) begin
          cnt <= cnt + 1'b1;
        end
      end
      if (chk_fire && (item.op == OP_SIGHTING)) begin
        if (mac_match) begin
          hit <= 1'b1;
        end
        if (!entry_v && !free_found) begin
          free_found <= 1'b1;
        end
      end
      if (chk_fire && (item.op == OP_SWEEP) && entry_v && aged) begin
        valid[chk_idx] <= 1'b0;
        if (drop_cnt != CNT_MAX) begin
          drop_cnt <= drop_cnt + 1'b1;
        end
      end
      if (wr_en) begin
        valid[sel_idx] <= 1'b1;
      end
    end
  end

  // Item payload and captured entry data.
  always_ff @(posedge clk) begin
    if (start && (state == ST_IDLE)) begin
      item <= item_in;
    end
    if (state == ST_SCAN) begin
      chk_idx <= rd_addr;
    end
    if (mac_match) begin
      hit_idx <= chk_idx;
      hit_rpt <= rd_data.rpt;
    end
    if (chk_fire && (item.op == OP_SIGHTING) && !entry_v && !free_found) begin
      free_idx <= chk_idx;
    end
  end

endmodule

`default_nettype wire

FILE: verif/tracked_device_table_with_ageout_tb.sv
`default_nettype none

module tracked_device_table_with_ageout_tb import tdt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES       = 32;
  localparam int SETTLE_CYCLES = 48;
  localparam int LIMIT_NS      = 5_000_000;
  localparam int LONG_HOLD     = 400;

  logic                      clk;
  logic                      rst;
  logic                      cfg_write;
  logic                      cfg_index;
  logic [TIME_W-1:0]         cfg_data;
  logic                      in_valid;
  logic                      in_stall;
  logic                      op;
  logic [MAC_W-1:0]          mac;
  logic signed [RSSI_W-1:0]  rssi;
  logic [SRC_W-1:0]          source;
  logic [TIME_W-1:0]         now_ms;
  logic                      out_valid;
  logic                      out_stall;
  logic                      report;
  logic [SLOT_W-1:0]         slot;
  logic                      new_entry;
  logic                      took_over;
  logic [MAC_W-1:0]          report_mac;
  logic signed [RSSI_W-1:0]  report_rssi;
  logic [SRC_W-1:0]          report_source;
  logic [CNT_W-1:0]          expired_count;

  // Shadow copy of the table, advanced once per accepted input beat, and of its registers.
  logic [TIME_W-1:0] rediscover_setting;
  logic [TIME_W-1:0] expire_setting;
  bit                entry_live     [ENTRIES];
  logic [MAC_W-1:0]  entry_mac      [ENTRIES];
  logic [TIME_W-1:0] entry_seen     [ENTRIES];
  logic [TIME_W-1:0] entry_reported [ENTRIES];
  logic [RSSI_W-1:0] entry_rssi     [ENTRIES];

  tdt_result_t       pending_results[$];
  int                mismatches;
  bit                tx_gaps;
  bit                rx_gaps;
  int                hold_requests;
  logic [TIME_W-1:0] clock_ms;
  logic [MAC_W-1:0]  mac_pool [64];

  tracked_device_table_with_ageout uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .op            (op),
    .mac           (mac),
    .rssi          (rssi),
    .source        (source),
    .now_ms        (now_ms),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .report        (report),
    .slot          (slot),
    .new_entry     (new_entry),
    .took_over     (took_over),
    .report_mac    (report_mac),
    .report_rssi   (report_rssi),
    .report_source (report_source),
    .expired_count (expired_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #(LIMIT_NS);
    $display("tracked_device_table_with_ageout verification failed");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("%0t MISMATCH %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("%s: got %0h, expected %0h", name, got, want));
    end
  endtask

  // Works out the result of one sighting or sweep and updates the shadow table.
  function automatic tdt_result_t predict_table_result(input tdt_item_t it);
    tdt_result_t       res;
    int                k;
    int                hit;
    logic [TIME_W-1:0] age;
    logic              fire;
    res = '0;
    if (it.op == OP_SWEEP) begin
      for (k = 0; k < ENTRIES; k++) begin
        age = it.now - entry_seen[k];
        if (entry_live[k] && age > expire_setting) begin
          entry_live[k] = 1'b0;
          if (res.expired != CNT_MAX) res.expired = res.expired + 1'b1;
        end
      end
    end else begin
      hit = -1;
      for (k = 0; k < ENTRIES; k++) begin
        if (hit < 0 && entry_live[k] && entry_mac[k] == it.mac) hit = k;
      end
      if (hit < 0) begin
        // No match: lowest free entry, or entry 0 when the table is full.
        res.new_entry = 1'b1;
        for (k = ENTRIES - 1; k >= 0; k--) begin
          if (!entry_live[k]) hit = k;
        end
        if (hit < 0) begin
          hit = 0;
          res.took_over = 1'b1;
        end
        entry_live[hit]     = 1'b1;
        entry_mac[hit]      = it.mac;
        entry_reported[hit] = '0;
      end
      // A stored report time of zero means the entry was never reported.
      age  = it.now - entry_reported[hit];
      fire = !(entry_reported[hit] != '0 && age < rediscover_setting);
      entry_seen[hit] = it.now;
      entry_rssi[hit] = it.rssi;
      if (fire) entry_reported[hit] = it.now;
      res.report = fire;
      res.slot   = hit[SLOT_W-1:0];
      res.mac    = entry_mac[hit];
      res.rssi   = entry_rssi[hit];
      res.source = it.source;
    end
    return res;
  endfunction

  function automatic logic [MAC_W-1:0] random_mac();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[MAC_W-1:0];
  endfunction

  function automatic logic [RSSI_W-1:0] random_rssi();
    return RSSI_W'($urandom);
  endfunction

  function automatic logic [SRC_W-1:0] random_source();
    return SRC_W'($urandom_range(0, 3));
  endfunction

  function automatic tdt_item_t sighting_item(input logic [MAC_W-1:0] addr,
                                              input logic [RSSI_W-1:0] strength,
                                              input logic [SRC_W-1:0] src,
                                              input logic [TIME_W-1:0] t);
    tdt_item_t it;
    it        = '0;
    it.op     = OP_SIGHTING;
    it.mac    = addr;
    it.rssi   = strength;
    it.source = src;
    it.now    = t;
    return it;
  endfunction

  // Sweep beats carry junk in the unused fields; the block must ignore it.
  function automatic tdt_item_t sweep_item(input logic [TIME_W-1:0] t);
    tdt_item_t it;
    it        = sighting_item(random_mac(), random_rssi(), random_source(), t);
    it.op     = OP_SWEEP;
    return it;
  endfunction

  // Offers one input beat, holds it until accepted and records its expected result.
  task automatic send_beat(input tdt_item_t it);
    int gap;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    op       <= it.op;
    mac      <= it.mac;
    rssi     <= it.rssi;
    source   <= it.source;
    now_ms   <= it.now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_table_result(it));
  endtask

  // Drops valid and waits until every result is back and the block is idle.
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [TIME_W-1:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_REDISCOVER) rediscover_setting = value;
    else expire_setting = value;
  endtask

  // Mostly sightings of a pool of known addresses on an advancing clock,
  // with occasional random sweeps and a few stray addresses at random times.
  task automatic run_traffic(input int count, input int pool, input int max_step,
                             input int sweep_pct);
    int n;
    int pick;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < sweep_pct) begin
        send_beat(sweep_item(clock_ms));
      end else if (pick < sweep_pct + 4) begin
        send_beat(sighting_item(random_mac(), random_rssi(), random_source(), $urandom));
      end else begin
        send_beat(sighting_item(mac_pool[$urandom_range(0, pool - 1)], random_rssi(),
                                random_source(), clock_ms));
      end
      clock_ms = clock_ms + $urandom_range(0, max_step);
    end
  endtask

  task automatic run_phase(input logic [TIME_W-1:0] rediscover,
                           input logic [TIME_W-1:0] expire, input int pool,
                           input int max_step, input int sweep_pct, input int count);
    settle_block();
    write_reg(REG_REDISCOVER, rediscover);
    write_reg(REG_EXPIRE, expire);
    run_traffic(count, pool, max_step, sweep_pct);
  endtask

  // Field extremes, report timing at the interval boundary, wrapped times,
  // never-reported entries, source value 3 and sweeps at extreme expiry times.
  task automatic test_field_extremes();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    write_reg(REG_REDISCOVER, 32'd1000);
    send_beat(sighting_item(48'h0, 8'h80, 2'd0, 32'd0));
    send_beat(sighting_item(48'h0, 8'd5, 2'd1, 32'd10));
    send_beat(sighting_item(48'h0, 8'd6, 2'd2, 32'd20));
    send_beat(sighting_item(48'h0, 8'd7, 2'd3, 32'd1010));
    send_beat(sighting_item('1, 8'h7f, 2'd3, 32'hffff_fff0));
    send_beat(sighting_item('1, 8'hff, 2'd1, 32'h0000_0100));
    send_beat(sighting_item(48'h8000_0000_0000, 8'd0, 2'd2, 32'd5000));
    send_beat(sighting_item(48'h0000_0000_0001, 8'd1, 2'd0, 32'd5000));
    send_beat(sweep_item(32'd5000));
    send_beat(sweep_item(32'd30257));
    send_beat(sighting_item('1, 8'h80, 2'd2, 32'd30257));
    settle_block();
    write_reg(REG_EXPIRE, 32'd0);
    write_reg(REG_REDISCOVER, '1);
    send_beat(sweep_item(32'd30257));
    send_beat(sweep_item(32'd30258));
    send_beat(sighting_item(48'h5555_5555_5555, 8'h80, 2'd0, 32'hffff_ffff));
    send_beat(sighting_item(48'h5555_5555_5555, 8'd0, 2'd1, 32'd0));
    send_beat(sighting_item(48'h5555_5555_5555, 8'd0, 2'd2, 32'h7fff_ffff));
    send_beat(sweep_item('1));
    settle_block();
    write_reg(REG_EXPIRE, '1);
    send_beat(sighting_item(48'haaaa_aaaa_aaaa, 8'd0, 2'd3, 32'd0));
    send_beat(sweep_item('1));
    send_beat(sighting_item(48'haaaa_aaaa_aaaa, 8'h7f, 2'd3, 32'd1));
    settle_block();
  endtask

  // Fills every entry, forces takeovers of entry 0, then punches holes with
  // a sweep and checks that new addresses land in the lowest free entries.
  task automatic test_full_table();
    logic [MAC_W-1:0] fill_macs [ENTRIES];
    int i;
    clock_ms = 32'h1000_0000;
    write_reg(REG_EXPIRE, 32'd0);
    write_reg(REG_REDISCOVER, 32'd100);
    send_beat(sweep_item(clock_ms));
    settle_block();
    write_reg(REG_EXPIRE, '1);
    for (i = 0; i < ENTRIES; i++) begin
      fill_macs[i] = random_mac();
      send_beat(sighting_item(fill_macs[i], random_rssi(), random_source(), clock_ms));
      clock_ms = clock_ms + 1;
    end
    for (i = 0; i < 6; i++) begin
      send_beat(sighting_item(random_mac(), random_rssi(), random_source(), clock_ms));
    end
    send_beat(sighting_item(fill_macs[ENTRIES - 1], random_rssi(), 2'd1, clock_ms));
    send_beat(sighting_item(fill_macs[0], random_rssi(), 2'd2, clock_ms));
    clock_ms = clock_ms + 200;
    for (i = 1; i < 16; i++) begin
      send_beat(sighting_item(fill_macs[i], random_rssi(), random_source(), clock_ms));
    end
    settle_block();
    write_reg(REG_EXPIRE, 32'd50);
    send_beat(sweep_item(clock_ms));
    for (i = 0; i < 5; i++) begin
      send_beat(sighting_item(random_mac(), random_rssi(), random_source(), clock_ms));
    end
    settle_block();
  endtask

  // Random traffic under several register settings, the extremes among them.
  task automatic test_random_phases();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    run_phase(32'd500, 32'd2000, 24, 100, 8, 250);
    run_phase(32'd0, 32'd0, 40, 3, 10, 150);
    clock_ms = 32'hffff_f000;
    run_phase('1, '1, 40, 50, 5, 150);
    run_phase(32'd3000, 32'd10000, 36, 400, 6, 250);
    run_phase(32'd200, 32'd1500, 30, 60, 8, 150);
    settle_block();
  endtask

  // The receiver holds off for a long stretch while beats keep coming, so
  // the block fills up and must stall its input.
  task automatic test_output_backpressure();
    tx_gaps = 1'b0;
    rx_gaps = 1'b1;
    hold_requests++;
    run_traffic(30, 32, 40, 8);
    settle_block();
  endtask

  // Last stretch at full rate with no idling on either side.
  task automatic test_unthrottled();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    run_phase(32'd100, 32'd800, 32, 40, 8, 200);
  endtask

  // Receiver stall: random bursts, a long hold on request, or none at all.
  initial begin : receiver_stall
    int burst_left;
    int run_left;
    int hold_left;
    int hold_served;
    burst_left  = 0;
    run_left    = 0;
    hold_left   = 0;
    hold_served = 0;
    out_stall   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != hold_served) begin
        hold_left   = LONG_HOLD;
        hold_served = hold_requests;
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!rx_gaps) begin
        out_stall <= 1'b0;
      end else if (burst_left != 0) begin
        out_stall <= 1'b1;
        burst_left--;
      end else begin
        out_stall <= 1'b0;
        if (run_left != 0) run_left--;
        else if ($urandom_range(0, 2) == 0) burst_left = $urandom_range(1, 17);
        else run_left = $urandom_range(0, 40);
      end
    end
  end

  // Compares each accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    tdt_result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        flag_mismatch("result beat with no sighting or sweep pending");
      end else begin
        want = pending_results.pop_front();
        check_field("report", report, want.report);
        check_field("slot", slot, want.slot);
        check_field("new_entry", new_entry, want.new_entry);
        check_field("took_over", took_over, want.took_over);
        check_field("report_mac", report_mac, want.mac);
        check_field("report_rssi", report_rssi, want.rssi);
        check_field("report_source", report_source, want.source);
        check_field("expired_count", expired_count, want.expired);
      end
    end
  end

  initial begin
    int i;
    rst                 = 1'b1;
    cfg_write           = 1'b0;
    cfg_index           = REG_REDISCOVER;
    cfg_data            = '0;
    in_valid            = 1'b0;
    op                  = OP_SIGHTING;
    mac                 = '0;
    rssi                = '0;
    source              = '0;
    now_ms              = '0;
    tx_gaps             = 1'b0;
    rx_gaps             = 1'b0;
    hold_requests       = 0;
    mismatches          = 0;
    clock_ms            = '0;
    rediscover_setting  = '0;
    expire_setting      = EXPIRE_RESET_MS;
    for (i = 0; i < ENTRIES; i++) begin
      entry_live[i]     = 1'b0;
      entry_mac[i]      = '0;
      entry_seen[i]     = '0;
      entry_reported[i] = '0;
      entry_rssi[i]     = '0;
    end
    // Every fourth address differs from its neighbor in one bit only.
    for (i = 0; i < 64; i++) begin
      if (i % 4 == 3) mac_pool[i] = mac_pool[i - 1] ^ (48'd1 << $urandom_range(0, 47));
      else mac_pool[i] = random_mac();
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_field_extremes();
    test_full_table();
    test_random_phases();
    test_output_backpressure();
    test_unthrottled();
    settle_block();

    if (mismatches == 0) begin
      $display("tracked_device_table_with_ageout verification clean");
    end else begin
      $display("tracked_device_table_with_ageout verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
